>>> hw/rtl/lpre_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lpre_pkg
// Shared types and constants for the length-prefixed reverse echo core.
// ----------------------------------------------------------------------------
package lpre_pkg;

    localparam logic       C_OP_BYTE  = 1'b0;
    localparam logic       C_OP_END   = 1'b1;

    localparam logic [7:0] C_DELIM    = 8'h2F;
    localparam logic [7:0] C_DIGIT_0  = 8'h30;
    localparam logic [7:0] C_DIGIT_9  = 8'h39;
    localparam int         C_RADIX    = 10;

    typedef enum logic [1:0] {
        ST_REPLY      = 2'd0,
        ST_BAD_FORMAT = 2'd1,
        ST_TOO_LONG   = 2'd2
    } t_status;

    // control shared by every cell of the stack chain
    typedef struct packed {
        logic push;
        logic pop;
    } t_stack_ctl;

endpackage
`default_nettype wire

>>> hw/rtl/lpre_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lpre_in_if / lpre_out_if
// Valid/ready channels for received bytes and for reply results.
// ----------------------------------------------------------------------------
interface lpre_in_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic [7:0] data_byte;

    modport source (output valid, output op, output data_byte, input ready);
    modport sink   (input valid, input op, input data_byte, output ready);
endinterface

interface lpre_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last;
    logic [1:0] status;

    modport source (output valid, output out_byte, output last, output status, input ready);
    modport sink   (input valid, input out_byte, input last, input status, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/lpre_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lpre_cell
// One byte of the body stack: takes the upper neighbor on push, the lower
// neighbor on pop, and holds otherwise.
// ----------------------------------------------------------------------------
module lpre_cell
    import lpre_pkg::*;
(
    input  wire logic       i_clk,
    input  wire t_stack_ctl i_ctl,
    input  wire logic [7:0] i_upper,
    input  wire logic [7:0] i_lower,
    output logic      [7:0] o_data
);

    logic [7:0] r_data;

    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_data <= i_upper;
        end else if (i_ctl.pop) begin
            r_data <= i_lower;
        end
    end

    assign o_data = r_data;

endmodule
`default_nettype wire

>>> hw/rtl/lpre_stack.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lpre_stack
// Last-in first-out byte store built as a chain of cells; cell 0 is the top.
// ----------------------------------------------------------------------------
module lpre_stack
    import lpre_pkg::*;
#(
    parameter int DEPTH = 32
) (
    input  wire logic       i_clk,
    input  wire t_stack_ctl i_ctl,
    input  wire logic [7:0] i_push_data,
    output logic      [7:0] o_top
);

    logic [7:0] w_data [DEPTH];

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [7:0] w_upper;
        logic [7:0] w_lower;

        if (g == 0) begin : g_head
            assign w_upper = i_push_data;
        end else begin : g_inner
            assign w_upper = w_data[g-1];
        end

        if (g == DEPTH - 1) begin : g_tail
            assign w_lower = 8'h00;
        end else begin : g_link
            assign w_lower = w_data[g+1];
        end

        lpre_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (i_ctl),
            .i_upper (w_upper),
            .i_lower (w_lower),
            .o_data  (w_data[g])
        );
    end

    assign o_top = w_data[0];

endmodule
`default_nettype wire

>>> hw/rtl/length_prefixed_reverse_echo_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// length_prefixed_reverse_echo_core
// Frame parser that echoes each body back reversed after its decimal length.
// ----------------------------------------------------------------------------
// While parsing a prefix or taking body bytes the core accepts one byte per
// cycle, provided the output register is empty or being drained. After the
// last body byte of a frame of length L the input stalls while the reply goes
// out, one result per cycle at full output ready: L+2 results for L below 10,
// L+3 otherwise, two for a zero-length frame. The body bytes sit in a chain of
// MAX_LEN byte cells that shifts down on every received body byte and up on
// every emitted one, so the reply is read from the head of the chain. An error
// is reported as a single result marked last; a connection-end transaction yields no result.
// ----------------------------------------------------------------------------
module length_prefixed_reverse_echo_core
    import lpre_pkg::*;
#(
    parameter int MAX_LEN = 32
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    lpre_in_if.sink     i_in,
    lpre_out_if.source  o_out
);

    // holds the prefix value saturated at MAX_LEN + 1
    localparam int LEN_W  = $clog2(MAX_LEN + 2);
    localparam int PROD_W = LEN_W + 4;
    localparam int CMP_W  = 7;

    typedef enum logic [6:0] {
        S_PREFIX = 7'b0000001,
        S_BODY   = 7'b0000010,
        S_ERROR  = 7'b0000100,
        S_TENS   = 7'b0001000,
        S_ONES   = 7'b0010000,
        S_DELIM  = 7'b0100000,
        S_POP    = 7'b1000000
    } t_state;

    t_state             r_state, n_state;
    logic [LEN_W-1:0]   r_len, n_len;
    logic               r_seen, n_seen;
    logic               r_bad, n_bad;
    logic [LEN_W-1:0]   r_count, n_count;
    logic               r_ov, n_ov;
    logic [7:0]         r_out_byte, n_out_byte;
    logic               r_last, n_last;
    t_status            r_status, n_status;

    logic               w_slot;
    logic               w_acc;
    logic               w_is_digit;
    logic [3:0]         w_digit;
    logic [PROD_W-1:0]  w_prod;
    logic [2:0]         w_tens;
    logic [CMP_W-1:0]   w_ones_full;
    logic [3:0]         w_ones;
    logic [7:0]         w_top;
    t_stack_ctl         w_ctl;

    assign w_slot = !r_ov || o_out.ready;
    assign i_in.ready = w_slot &&
        (r_state == S_PREFIX || r_state == S_BODY || r_state == S_ERROR);
    assign w_acc = i_in.valid && i_in.ready;

    assign w_is_digit = (i_in.data_byte >= C_DIGIT_0) && (i_in.data_byte <= C_DIGIT_9);
    assign w_digit    = i_in.data_byte[3:0];
    assign w_prod     = PROD_W'(r_len) * PROD_W'(C_RADIX) + PROD_W'(w_digit);

    // split the length into two decimal digits
    always_comb begin
        w_tens = 3'd0;
        for (int k = 1; k <= 6; k++) begin
            if (CMP_W'(r_len) >= CMP_W'(C_RADIX * k)) begin
                w_tens = w_tens + 3'd1;
            end
        end
    end

    assign w_ones_full = CMP_W'(r_len) - CMP_W'(w_tens) * CMP_W'(C_RADIX);
    assign w_ones      = w_ones_full[3:0];

    assign w_ctl.push = w_acc && (i_in.op == C_OP_BYTE) && (r_state == S_BODY);
    assign w_ctl.pop  = (r_state == S_POP) && w_slot;

    lpre_stack #(
        .DEPTH (MAX_LEN)
    ) u_stack (
        .i_clk       (i_clk),
        .i_ctl       (w_ctl),
        .i_push_data (i_in.data_byte),
        .o_top       (w_top)
    );

    always_comb begin
        n_state    = r_state;
        n_len      = r_len;
        n_seen     = r_seen;
        n_bad      = r_bad;
        n_count    = r_count;
        n_ov       = r_ov && !o_out.ready;
        n_out_byte = r_out_byte;
        n_last     = r_last;
        n_status   = r_status;

        if (w_acc && i_in.op == C_OP_END) begin
            n_state = S_PREFIX;
            n_len   = '0;
            n_seen  = 1'b0;
            n_bad   = 1'b0;
            n_count = '0;
        end else if (w_acc) begin
            unique case (r_state)
                S_PREFIX: begin
                    if (i_in.data_byte == C_DELIM) begin
                        if (!r_seen || r_bad) begin
                            n_ov       = 1'b1;
                            n_out_byte = 8'h00;
                            n_last     = 1'b1;
                            n_status   = ST_BAD_FORMAT;
                            n_state    = S_ERROR;
                        end else if (r_len > LEN_W'(MAX_LEN)) begin
                            n_ov       = 1'b1;
                            n_out_byte = 8'h00;
                            n_last     = 1'b1;
                            n_status   = ST_TOO_LONG;
                            n_state    = S_ERROR;
                        end else if (r_len == '0) begin
                            n_state = S_ONES;
                        end else begin
                            n_state = S_BODY;
                            n_count = '0;
                        end
                    end else if (w_is_digit) begin
                        if (w_prod > PROD_W'(MAX_LEN + 1)) begin
                            n_len = LEN_W'(MAX_LEN + 1);
                        end else begin
                            n_len = w_prod[LEN_W-1:0];
                        end
                        n_seen = 1'b1;
                    end else begin
                        n_bad = 1'b1;
                    end
                end
                S_BODY: begin
                    n_count = r_count + LEN_W'(1);
                    if (r_count + LEN_W'(1) == r_len) begin
                        n_state = (CMP_W'(r_len) >= CMP_W'(C_RADIX)) ? S_TENS : S_ONES;
                    end
                end
                default: begin
                    // error mode: drop the byte
                end
            endcase
        end else if (w_slot) begin
            unique case (r_state)
                S_TENS: begin
                    n_ov       = 1'b1;
                    n_out_byte = C_DIGIT_0 + 8'(w_tens);
                    n_last     = 1'b0;
                    n_status   = ST_REPLY;
                    n_state    = S_ONES;
                end
                S_ONES: begin
                    n_ov       = 1'b1;
                    n_out_byte = C_DIGIT_0 + 8'(w_ones);
                    n_last     = 1'b0;
                    n_status   = ST_REPLY;
                    n_state    = S_DELIM;
                end
                S_DELIM: begin
                    n_ov       = 1'b1;
                    n_out_byte = C_DELIM;
                    n_last     = (r_len == '0);
                    n_status   = ST_REPLY;
                    n_count    = r_len;
                    if (r_len == '0) begin
                        n_state = S_PREFIX;
                        n_seen  = 1'b0;
                        n_bad   = 1'b0;
                    end else begin
                        n_state = S_POP;
                    end
                end
                S_POP: begin
                    n_ov       = 1'b1;
                    n_out_byte = w_top;
                    n_last     = (r_count == LEN_W'(1));
                    n_status   = ST_REPLY;
                    n_count    = r_count - LEN_W'(1);
                    if (r_count == LEN_W'(1)) begin
                        n_state = S_PREFIX;
                        n_len   = '0;
                        n_seen  = 1'b0;
                        n_bad   = 1'b0;
                    end
                end
                default: begin
                    // parsing states wait for input
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_PREFIX;
            r_len   <= '0;
            r_seen  <= 1'b0;
            r_bad   <= 1'b0;
            r_count <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_len   <= n_len;
            r_seen  <= n_seen;
            r_bad   <= n_bad;
            r_count <= n_count;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_byte <= n_out_byte;
        r_last     <= n_last;
        r_status   <= n_status;
    end

    assign o_out.valid    = r_ov;
    assign o_out.out_byte = r_out_byte;
    assign o_out.last     = r_last;
    assign o_out.status   = r_status;

endmodule
`default_nettype wire
